[hdl/fwgs_pkg.sv]
// Shared types, codes and helper functions for the falling-water grid sweep.
// Used by falling_water_grid_sweep and its port checker; depends on nothing.

package fwgs_pkg;

    // Grid size defaults, handed to the top-level parameters
    localparam int unsigned DEF_MAX_COLS = 64;
    localparam int unsigned DEF_MAX_ROWS = 64;

    // Request codes, also returned on done_type
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_SWEEP = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SEED   = 2'd2;

    // Cell codes
    localparam logic [1:0] CELL_EMPTY = 2'd0;
    localparam logic [1:0] CELL_WATER = 2'd1;

    // Spread step codes, as (lfsr mod 3)
    localparam logic [1:0] STEP_LEFT  = 2'd0;
    localparam logic [1:0] STEP_HOLD  = 2'd1;
    localparam logic [1:0] STEP_RIGHT = 2'd2;

    localparam logic [6:0]  RST_GRID_WIDTH  = 7'd64;
    localparam logic [6:0]  RST_GRID_HEIGHT = 7'd64;
    localparam logic [15:0] SEED_DEFAULT    = 16'd44257;
    localparam logic [15:0] LFSR_TAPS       = 16'hB400;

    localparam logic signed [2:0] RV_ZERO  = 3'sd0;
    localparam logic signed [2:0] RV_OUTSIDE = -3'sd1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SW_HERE,
        ST_SW_EVAL,
        ST_SW_FALL,
        ST_SW_FALL2,
        ST_SW_BELOW,
        ST_SW_STEP,
        ST_SW_TGT,
        ST_SW_MOVE
    } t_state;

    // Galois LFSR, shifting right, taps folded in when a one drops out
    function automatic logic [15:0] lfsr_next(input logic [15:0] s);
        logic [15:0] t;
        begin
            t = s >> 1;
            if (s[0]) begin
                t = t ^ LFSR_TAPS;
            end
            return t;
        end
    endfunction

    // Seed of zero falls back to the default
    function automatic logic [15:0] seed_load(input logic [15:0] seed);
        begin
            return (seed == 16'd0) ? SEED_DEFAULT : seed;
        end
    endfunction

    // x mod 3: base-4 digits sum to the same residue, fold twice then trim
    function automatic logic [1:0] mod3_16(input logic [15:0] x);
        logic [4:0] s;
        logic [2:0] t;
        begin
            s = 5'd0;
            for (int i = 0; i < 8; i++) begin
                s = s + 5'(x[2*i +: 2]);
            end
            t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
            if (t >= 3'd6) begin
                t = t - 3'd6;
            end else if (t >= 3'd3) begin
                t = t - 3'd3;
            end
            return t[1:0];
        end
    endfunction

endpackage

[hdl/falling_water_grid_sweep.sv]
// Falling-water grid: cell memory, request sequencer and sweep engine.
// Depends on fwgs_pkg.

// A write, an out-of-range read, a sweep over an empty area and any request other
// than read or sweep answer in the cycle after start is taken; an in-range read
// answers through ST_READ from the registered memory data. A sweep visits the active
// area cell by cell through the single cell memory: each cell is read (ST_SW_HERE,
// ST_SW_EVAL); an empty cell below the top row reads the cell above and, if it holds
// water, moves it down; water resting on water draws a step from the LFSR and may
// move sideways into an empty neighbour. The answer follows in the cycle after the last cell.
// After reset the block clears MAX_COLS*MAX_ROWS cells, one a cycle, and holds
// busy high meanwhile; configuration writes are taken at any time. Results are
// shown for one cycle on o_done and cannot be stalled.

module falling_water_grid_sweep
    import fwgs_pkg::*;
#(
    parameter int unsigned MAX_COLS = DEF_MAX_COLS,
    parameter int unsigned MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_req_type,
    input  logic [6:0]        i_col,
    input  logic [6:0]        i_row,
    input  logic [1:0]        i_write_value,
    output logic              o_done,
    output logic [1:0]        o_done_type,
    output logic signed [2:0] o_read_value,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    localparam int unsigned DEPTH   = MAX_COLS * MAX_ROWS;
    localparam int unsigned ADDR_W  = $clog2(DEPTH);
    localparam int unsigned COL_CAP = (MAX_COLS > 127) ? 127 : MAX_COLS;
    localparam int unsigned ROW_CAP = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
    localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(MAX_COLS);
    localparam logic [ADDR_W-1:0] ONE_A  = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(DEPTH - 1);

    logic [1:0] mem [DEPTH];

    t_state            r_state, n_state;
    logic [6:0]        r_width, r_height;
    logic [6:0]        r_col, n_col;
    logic [6:0]        r_row, n_row;
    logic              r_right, n_right;
    logic [15:0]       r_lfsr, n_lfsr;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic              r_done, n_done;
    logic [1:0]        r_done_type, n_done_type;
    logic signed [2:0] r_read_value, n_read_value;
    logic [1:0]        r_rdata;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa, mem_ra;
    logic [1:0]        mem_wd;

    logic [6:0]        act_w, act_h;
    logic              in_ok, adv;
    logic [ADDR_W-1:0] in_addr, cur_addr, tgt_addr;
    logic [1:0]        step;

    assign act_w = (r_width > 7'(COL_CAP)) ? 7'(COL_CAP) : r_width;
    assign act_h = (r_height > 7'(ROW_CAP)) ? 7'(ROW_CAP) : r_height;

    assign in_ok    = (i_col < act_w) && (i_row < act_h);
    assign in_addr  = ADDR_W'(i_row) * COLS_A + ADDR_W'(i_col);
    assign cur_addr = ADDR_W'(r_row) * COLS_A + ADDR_W'(r_col);
    assign tgt_addr = r_right ? (cur_addr + ONE_A) : (cur_addr - ONE_A);
    assign step     = mod3_16(r_lfsr);

    assign busy         = (r_state != ST_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_done       = r_done;
    assign o_done_type  = r_done_type;
    assign o_read_value = r_read_value;

    // Cell memory: one write port, one read port, registered read data
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_done   <= 1'b0;
            r_width  <= RST_GRID_WIDTH;
            r_height <= RST_GRID_HEIGHT;
            r_lfsr   <= SEED_DEFAULT;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
            r_lfsr  <= n_lfsr;
            if (i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_WIDTH)) begin
                r_width <= i_cfg_data[6:0];
            end
            if (i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_HEIGHT)) begin
                r_height <= i_cfg_data[6:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col        <= n_col;
        r_row        <= n_row;
        r_right      <= n_right;
        r_done_type  <= n_done_type;
        r_read_value <= n_read_value;
    end

    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        n_row        = r_row;
        n_right      = r_right;
        n_lfsr       = r_lfsr;
        n_clr        = r_clr;
        n_done       = 1'b0;
        n_done_type  = r_done_type;
        n_read_value = r_read_value;
        mem_we       = 1'b0;
        mem_wa       = cur_addr;
        mem_wd       = CELL_EMPTY;
        mem_ra       = cur_addr;
        adv          = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                n_clr  = r_clr + ONE_A;
                if (r_clr == LAST_A) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    case (i_req_type)
                        REQ_WRITE: begin
                            mem_we       = in_ok;
                            mem_wa       = in_addr;
                            mem_wd       = i_write_value;
                            n_done       = 1'b1;
                            n_done_type  = REQ_WRITE;
                            n_read_value = RV_ZERO;
                        end
                        REQ_READ: begin
                            if (in_ok) begin
                                mem_ra  = in_addr;
                                n_state = ST_READ;
                            end else begin
                                n_done       = 1'b1;
                                n_done_type  = REQ_READ;
                                n_read_value = RV_OUTSIDE;
                            end
                        end
                        REQ_SWEEP: begin
                            if ((act_w == 7'd0) || (act_h == 7'd0)) begin
                                n_done       = 1'b1;
                                n_done_type  = REQ_SWEEP;
                                n_read_value = RV_ZERO;
                            end else begin
                                n_col   = 7'd0;
                                n_row   = act_h - 7'd1;
                                n_state = ST_SW_HERE;
                            end
                        end
                        default: begin
                            n_done       = 1'b1;
                            n_done_type  = i_req_type;
                            n_read_value = RV_ZERO;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_done       = 1'b1;
                n_done_type  = REQ_READ;
                n_read_value = 3'({1'b0, r_rdata});
                n_state      = ST_IDLE;
            end
            ST_SW_HERE: begin
                n_state = ST_SW_EVAL;
            end
            ST_SW_EVAL: begin
                if ((r_rdata == CELL_EMPTY) && (r_row != 7'd0)) begin
                    mem_ra  = cur_addr - COLS_A;
                    n_state = ST_SW_FALL;
                end else if ((r_rdata == CELL_WATER) && ((r_row + 7'd1) < act_h)) begin
                    mem_ra  = cur_addr + COLS_A;
                    n_state = ST_SW_BELOW;
                end else begin
                    adv = 1'b1;
                end
            end
            ST_SW_FALL: begin
                if (r_rdata == CELL_WATER) begin
                    mem_we  = 1'b1;
                    mem_wd  = CELL_WATER;
                    n_state = ST_SW_FALL2;
                end else begin
                    adv = 1'b1;
                end
            end
            ST_SW_FALL2: begin
                mem_we = 1'b1;
                mem_wa = cur_addr - COLS_A;
                mem_wd = CELL_EMPTY;
                adv    = 1'b1;
            end
            ST_SW_BELOW: begin
                if (r_rdata == CELL_WATER) begin
                    n_lfsr  = lfsr_next(r_lfsr);
                    n_state = ST_SW_STEP;
                end else begin
                    adv = 1'b1;
                end
            end
            ST_SW_STEP: begin
                // neighbour outside the active area counts as occupied
                case (step)
                    STEP_LEFT: begin
                        if (r_col != 7'd0) begin
                            mem_ra  = cur_addr - ONE_A;
                            n_right = 1'b0;
                            n_state = ST_SW_TGT;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    STEP_RIGHT: begin
                        if ((r_col + 7'd1) < act_w) begin
                            mem_ra  = cur_addr + ONE_A;
                            n_right = 1'b1;
                            n_state = ST_SW_TGT;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    default: begin
                        adv = 1'b1;
                    end
                endcase
            end
            ST_SW_TGT: begin
                if (r_rdata == CELL_EMPTY) begin
                    mem_we  = 1'b1;
                    mem_wd  = CELL_EMPTY;
                    n_state = ST_SW_MOVE;
                end else begin
                    adv = 1'b1;
                end
            end
            ST_SW_MOVE: begin
                mem_we = 1'b1;
                mem_wa = tgt_addr;
                mem_wd = CELL_WATER;
                adv    = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // advance along the row, then up one row; finish after the top row
        if (adv) begin
            if ((r_col + 7'd1) < act_w) begin
                n_col   = r_col + 7'd1;
                n_state = ST_SW_HERE;
            end else if (r_row == 7'd0) begin
                n_done       = 1'b1;
                n_done_type  = REQ_SWEEP;
                n_read_value = RV_ZERO;
                n_state      = ST_IDLE;
            end else begin
                n_col   = 7'd0;
                n_row   = r_row - 7'd1;
                n_state = ST_SW_HERE;
            end
        end

        // a seed write loads the LFSR at once
        if (i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_SEED)) begin
            n_lfsr = seed_load(i_cfg_data);
        end
    end

endmodule

[hdl/fwgs_chk.sv]
// Port-level checker for falling_water_grid_sweep, bound to the top level.
// Depends on fwgs_pkg.

module fwgs_chk
    import fwgs_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic [1:0]        i_req_type,
    input logic              o_done,
    input logic [1:0]        o_done_type,
    input logic signed [2:0] o_read_value
);

    // the cell clear runs straight after reset
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low after reset");

    // an accepted item either answers next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted item neither answered nor held busy");

    // only reads return a non-zero value
    a_value_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_done_type != REQ_READ)) |-> (o_read_value == RV_ZERO))
        else $error("non-zero value on a non-read result");

    // read values lie in -1..3
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_read_value != -3'sd2 && o_read_value != -3'sd3 &&
                    o_read_value != -3'sd4))
        else $error("read value out of range");

    // every result follows an accept or a busy cycle
    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) || $past(start && !busy)))
        else $error("result without a pending item");

endmodule

bind falling_water_grid_sweep fwgs_chk u_fwgs_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_req_type   (i_req_type),
    .o_done       (o_done),
    .o_done_type  (o_done_type),
    .o_read_value (o_read_value)
);
